FILE: rtl/core/decimal96_to_ascii_top_assert.svh
// Assertion macros for the decimal-to-text block checker.
`ifndef DECIMAL96_TO_ASCII_TOP_ASSERT_SVH
`define DECIMAL96_TO_ASCII_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define D96A_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define D96A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/d96a_pkg.sv
package d96a_pkg;

  localparam int MANT_BITS   = 96;
  localparam int MAX_SCALE   = 28;
  localparam int MAX_RESULTS = 32;

  localparam int CONV_BITS  = (MANT_BITS > 96) ? 96 : MANT_BITS;
  localparam int NUM_DIGITS = (CONV_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int CNT_W      =
    $clog2(((NUM_DIGITS > MAX_SCALE) ? NUM_DIGITS : MAX_SCALE) + 1);
  localparam int STEP_W     = $clog2(CONV_BITS + 1);
  localparam int EMIT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_NL    = 8'h0A;
  localparam logic [7:0] ASCII_NUL   = 8'h00;

  typedef struct packed {
    logic [63:0] mant_low;
    logic [31:0] mant_high;
    logic [7:0]  scale;
    logic        negative;
    logic [3:0]  value_type;
  } num_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } text_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_STEP,
    CMD_SHIFT
  } dab_cmd_t;

  typedef struct packed {
    dab_cmd_t               cmd;
    logic [CONV_BITS-1:0]   mant;
  } dab_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN,
    ST_ZERO,
    ST_BODY,
    ST_NL,
    ST_ERR
  } seq_state_t;

endpackage

FILE: rtl/core/d96a_dabble.sv
module d96a_dabble import d96a_pkg::*; (
  input  logic       clk,
  input  dab_ctrl_t  ctrl,
  output logic [3:0] top_digit
);

  logic [CONV_BITS-1:0] bin;
  logic [CONV_BITS-1:0] bin_next;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_next;
  logic [BCD_W-1:0]     bcd_adj;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
    bin_next = bin;
    bcd_next = bcd;
    case (ctrl.cmd)
      CMD_LOAD: begin
        bin_next = ctrl.mant;
        bcd_next = '0;
      end
      CMD_STEP: begin
        bcd_next = {bcd_adj[BCD_W-2:0], bin[CONV_BITS-1]};
        bin_next = {bin[CONV_BITS-2:0], 1'b0};
      end
      CMD_SHIFT: begin
        bcd_next = {bcd[BCD_W-5:0], 4'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bin <= bin_next;
    bcd <= bcd_next;
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

endmodule

FILE: rtl/core/d96a_obuf.sv
module d96a_obuf import d96a_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  text_t push_item,
  output logic  free,
  output logic  text_valid,
  input  logic  text_stall,
  output text_t text
);

  assign free = !text_valid || !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (free) begin
      text_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      text <= push_item;
    end
  end

endmodule

FILE: rtl/core/d96a_seq.sv
module d96a_seq import d96a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       num_valid,
  output logic       num_stall,
  input  num_t       num,
  input  logic [3:0] top_digit,
  output dab_ctrl_t  ctrl,
  input  logic       free,
  output logic       push,
  output text_t      push_item
);

  seq_state_t        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic [CNT_W-1:0]  dig_left, dig_left_next;
  logic [CNT_W-1:0]  int_left, int_left_next;
  logic [CNT_W-1:0]  pad, pad_next;
  logic [CNT_W-1:0]  scale, scale_next;
  logic [EMIT_W-1:0] emit_cnt, emit_cnt_next;
  logic              point_pending, point_pending_next;
  logic              neg, neg_next;
  logic              lead_zero, lead_zero_next;
  logic [95:0]       mant_full;
  logic              bad;

  assign mant_full = {num.mant_high, num.mant_low};
  assign bad = (num.value_type != 4'd0) || (num.scale > 8'(MAX_SCALE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    step_cnt      <= step_cnt_next;
    dig_left      <= dig_left_next;
    int_left      <= int_left_next;
    pad           <= pad_next;
    scale         <= scale_next;
    emit_cnt      <= emit_cnt_next;
    point_pending <= point_pending_next;
    neg           <= neg_next;
    lead_zero     <= lead_zero_next;
  end

  always_comb begin
    state_next         = state;
    step_cnt_next      = step_cnt;
    dig_left_next      = dig_left;
    int_left_next      = int_left;
    pad_next           = pad;
    scale_next         = scale;
    emit_cnt_next      = emit_cnt;
    point_pending_next = point_pending;
    neg_next           = neg;
    lead_zero_next     = lead_zero;
    ctrl.cmd           = CMD_HOLD;
    ctrl.mant          = mant_full[CONV_BITS-1:0];
    push               = 1'b0;
    push_item          = '0;
    num_stall          = (state != ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (num_valid) begin
          emit_cnt_next = '0;
          neg_next      = num.negative;
          scale_next    = num.scale[CNT_W-1:0];
          if (bad) begin
            state_next = ST_ERR;
          end else begin
            ctrl.cmd      = CMD_LOAD;
            step_cnt_next = STEP_W'(CONV_BITS);
            state_next    = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        ctrl.cmd      = CMD_STEP;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == STEP_W'(1)) begin
          dig_left_next = CNT_W'(NUM_DIGITS);
          state_next    = ST_NORM;
        end
      end
      ST_NORM: begin
        if (top_digit == 4'd0 && dig_left != CNT_W'(1)) begin
          ctrl.cmd      = CMD_SHIFT;
          dig_left_next = dig_left - 1'b1;
        end else begin
          if (scale >= dig_left) begin
            lead_zero_next     = 1'b1;
            pad_next           = scale - dig_left;
            int_left_next      = '0;
            point_pending_next = 1'b1;
          end else begin
            lead_zero_next     = 1'b0;
            pad_next           = '0;
            int_left_next      = dig_left - scale;
            point_pending_next = (scale != '0);
          end
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!neg) begin
          state_next = lead_zero ? ST_ZERO : ST_BODY;
        end else if (free) begin
          push                = 1'b1;
          push_item.character = ASCII_MINUS;
          state_next          = lead_zero ? ST_ZERO : ST_BODY;
        end
      end
      ST_ZERO: begin
        if (free) begin
          push                = 1'b1;
          push_item.character = ASCII_ZERO;
          state_next          = ST_BODY;
        end
      end
      ST_BODY: begin
        if (free) begin
          push = 1'b1;
          if (point_pending && int_left == '0) begin
            push_item.character = ASCII_POINT;
            point_pending_next  = 1'b0;
          end else if (pad != '0) begin
            push_item.character = ASCII_ZERO;
            pad_next            = pad - 1'b1;
          end else begin
            push_item.character = ASCII_ZERO + {4'd0, top_digit};
            ctrl.cmd            = CMD_SHIFT;
            dig_left_next       = dig_left - 1'b1;
            if (int_left != '0) begin
              int_left_next = int_left - 1'b1;
            end
            if (dig_left == CNT_W'(1)) begin
              state_next = ST_NL;
            end
          end
        end
      end
      ST_NL: begin
        if (free) begin
          push                = 1'b1;
          push_item.character = ASCII_NL;
          push_item.last      = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (free) begin
          push                = 1'b1;
          push_item.character = ASCII_NUL;
          push_item.last      = 1'b1;
          push_item.error     = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (push) begin
      emit_cnt_next = emit_cnt + 1'b1;
      if (emit_cnt == EMIT_W'(MAX_RESULTS - 1)) begin
        state_next = ST_IDLE;
      end
    end
  end

endmodule

FILE: rtl/core/decimal96_to_ascii_top.sv
// Renders a scaled decimal number (96-bit unsigned mantissa, power-of-ten
// scale, sign, type code) as ASCII text, one character per transfer.
// Input channel num: num_valid/num_stall with a num_t payload. One number
// is taken at a time; num_stall stays high from the transfer until the
// newline (or the error result) has been loaded into the output register.
// Output channel text: text_valid/text_stall with a text_t payload. The
// last flag marks the newline; an invalid type or a scale above the limit
// gives one result with error and last set and a NUL character.
// Conversion: a load, 96 double-dabble steps on the shared BCD shift-add
// unit, leading-zero normalization, then one character per cycle while
// the receiver accepts.
// A stalled receiver holds the output register and freezes the character
// sequencer; nothing is dropped. Reset clears the sequencer and the output
// valid; the next number may arrive the cycle after reset drops.
module decimal96_to_ascii_top import d96a_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  num_valid,
  output logic  num_stall,
  input  num_t  num,
  output logic  text_valid,
  input  logic  text_stall,
  output text_t text
);

  dab_ctrl_t  ctrl;
  logic [3:0] top_digit;
  logic       free;
  logic       push;
  text_t      push_item;

  d96a_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .num       (num),
    .top_digit (top_digit),
    .ctrl      (ctrl),
    .free      (free),
    .push      (push),
    .push_item (push_item)
  );

  d96a_dabble u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .top_digit (top_digit)
  );

  d96a_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .free       (free),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

endmodule

FILE: rtl/core/d96a_check.sv
`include "decimal96_to_ascii_top_assert.svh"

module d96a_check import d96a_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  num_valid,
  input logic  num_stall,
  input logic  text_valid,
  input logic  text_stall,
  input text_t text
);

  `D96A_ASSERT_NEXT(a_text_hold, text_valid && text_stall,
                    text_valid && $stable(text), "stalled text transfer changed")
  `D96A_ASSERT_NEXT(a_busy_after_take, num_valid && !num_stall,
                    num_stall, "input taken again without a busy cycle")
  `D96A_ASSERT_SAME(a_error_shape, text_valid && text.error,
                    text.last && text.character == ASCII_NUL, "malformed error result")
  `D96A_ASSERT_SAME(a_text_nonzero, text_valid && !text.error,
                    text.character != ASCII_NUL, "null character in text")

endmodule

bind decimal96_to_ascii_top d96a_check u_check (.*);
